// File: hw/rtl/bstc_pkg.sv
// ----------------------------------------------------------------------------
// bstc_pkg
// Types, operation codes and flag mask bits of the 64-bit bit scan, test and
// count unit.
// ----------------------------------------------------------------------------
package bstc_pkg;

    localparam int WORD_W = 64;
    localparam int SEL_W  = 6;
    localparam int CNT_W  = 7;
    localparam int MASK_W = 6;

    // Operation codes.
    localparam logic [3:0] ACT_BSF    = 4'd0;
    localparam logic [3:0] ACT_BSR    = 4'd1;
    localparam logic [3:0] ACT_BT     = 4'd2;
    localparam logic [3:0] ACT_BTS    = 4'd3;
    localparam logic [3:0] ACT_BTR    = 4'd4;
    localparam logic [3:0] ACT_BTC    = 4'd5;
    localparam logic [3:0] ACT_POPCNT = 4'd6;
    localparam logic [3:0] ACT_TZCNT  = 4'd7;
    localparam logic [3:0] ACT_LZCNT  = 4'd8;
    localparam logic [3:0] ACT_BITADR = 4'd9;

    // Flag write mask bits.
    localparam logic [MASK_W-1:0] MSK_CF  = 6'h01;
    localparam logic [MASK_W-1:0] MSK_PF  = 6'h02;
    localparam logic [MASK_W-1:0] MSK_AF  = 6'h04;
    localparam logic [MASK_W-1:0] MSK_ZF  = 6'h08;
    localparam logic [MASK_W-1:0] MSK_SF  = 6'h10;
    localparam logic [MASK_W-1:0] MSK_OF  = 6'h20;
    localparam logic [MASK_W-1:0] MSK_ALL = 6'h3f;

    typedef struct packed {
        logic [3:0]        action;
        logic [WORD_W-1:0] source_value;
        logic [WORD_W-1:0] bit_offset;
        logic [WORD_W-1:0] base_address;
        logic              addr_is_64;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] result_value;
        logic              dest_write;
        logic              carry_flag;
        logic              parity_flag;
        logic              adjust_flag;
        logic              zero_flag;
        logic              sign_flag;
        logic              overflow_flag;
        logic [MASK_W-1:0] flag_write_mask;
    } rsp_t;

endpackage

// File: hw/rtl/bstc_popcount.sv
// ----------------------------------------------------------------------------
// bstc_popcount
// Adder tree that counts the set bits of a 64-bit word.
// ----------------------------------------------------------------------------
module bstc_popcount
(
    input  logic [bstc_pkg::WORD_W-1:0] word,
    output logic [bstc_pkg::CNT_W-1:0]  count
);
    import bstc_pkg::*;

    logic [1:0] lvl1 [32];
    logic [2:0] lvl2 [16];
    logic [3:0] lvl3 [8];
    logic [4:0] lvl4 [4];
    logic [5:0] lvl5 [2];

    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            lvl1[i] = {1'b0, word[2*i]} + {1'b0, word[2*i+1]};
        end
        for (int i = 0; i < 16; i++)
        begin
            lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
        end
        for (int i = 0; i < 8; i++)
        begin
            lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            lvl4[i] = {1'b0, lvl3[2*i]} + {1'b0, lvl3[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            lvl5[i] = {1'b0, lvl4[2*i]} + {1'b0, lvl4[2*i+1]};
        end
        count = {1'b0, lvl5[0]} + {1'b0, lvl5[1]};
    end

endmodule

// File: hw/rtl/bstc_exec.sv
// ----------------------------------------------------------------------------
// bstc_exec
// Combinational datapath: scans, bit tests, counts and the bit-string
// address step for one item.
// ----------------------------------------------------------------------------
module bstc_exec
(
    input  bstc_pkg::req_t op,
    output bstc_pkg::rsp_t res
);
    import bstc_pkg::*;

    logic [SEL_W-1:0]  sel;
    logic [WORD_W-1:0] bit_mask;
    logic [WORD_W-1:0] src_rev;
    logic [WORD_W-1:0] scan_in;
    logic [WORD_W-1:0] low_fill;
    logic [WORD_W-1:0] cnt_in;
    logic [WORD_W-1:0] qword_step;
    logic [WORD_W-1:0] bit_addr;
    logic [CNT_W-1:0]  cnt;
    logic              scan_rev;
    logic              src_zero;

    // Trailing zero count is the population count of the ones below the
    // lowest set bit; leading zeros use the same path on the reversed word.
    always_comb
    begin
        for (int i = 0; i < WORD_W; i++)
        begin
            src_rev[i] = op.source_value[WORD_W-1-i];
        end
        scan_rev = (op.action == ACT_BSR) || (op.action == ACT_LZCNT);
        scan_in  = scan_rev ? src_rev : op.source_value;
        low_fill = (scan_in - 64'd1) & ~scan_in;
        cnt_in   = (op.action == ACT_POPCNT) ? op.source_value : low_fill;
    end

    bstc_popcount u_popcount
    (
        .word  (cnt_in),
        .count (cnt)
    );

    always_comb
    begin
        sel        = op.bit_offset[SEL_W-1:0];
        bit_mask   = 64'd1 << sel;
        src_zero   = (op.source_value == '0);
        // Arithmetic shift by six then times eight, as one sign-filled field.
        qword_step = {{3{op.bit_offset[WORD_W-1]}}, op.bit_offset[WORD_W-1:SEL_W], 3'b000};
        bit_addr   = op.base_address + qword_step;

        res = '0;
        case (op.action)
            ACT_BSF, ACT_BSR:
            begin
                if (src_zero)
                begin
                    res.zero_flag       = 1'b1;
                    res.flag_write_mask = MSK_ZF;
                end
                else
                begin
                    if (op.action == ACT_BSF)
                    begin
                        res.result_value = {58'd0, cnt[SEL_W-1:0]};
                    end
                    else
                    begin
                        res.result_value = {58'd0, 6'd63 - cnt[SEL_W-1:0]};
                    end
                    res.dest_write      = 1'b1;
                    res.parity_flag     = ~^res.result_value[7:0];
                    res.sign_flag       = res.result_value[WORD_W-1];
                    res.flag_write_mask = MSK_ALL;
                end
            end
            ACT_BT:
            begin
                res.result_value    = op.source_value;
                res.carry_flag      = op.source_value[sel];
                res.flag_write_mask = MSK_CF;
            end
            ACT_BTS:
            begin
                res.result_value    = op.source_value | bit_mask;
                res.dest_write      = 1'b1;
                res.carry_flag      = op.source_value[sel];
                res.flag_write_mask = MSK_CF;
            end
            ACT_BTR:
            begin
                res.result_value    = op.source_value & ~bit_mask;
                res.dest_write      = 1'b1;
                res.carry_flag      = op.source_value[sel];
                res.flag_write_mask = MSK_CF;
            end
            ACT_BTC:
            begin
                res.result_value    = op.source_value ^ bit_mask;
                res.dest_write      = 1'b1;
                res.carry_flag      = op.source_value[sel];
                res.flag_write_mask = MSK_CF;
            end
            ACT_POPCNT:
            begin
                res.result_value    = {57'd0, cnt};
                res.dest_write      = 1'b1;
                res.zero_flag       = (cnt == '0);
                res.flag_write_mask = MSK_ALL;
            end
            ACT_TZCNT, ACT_LZCNT:
            begin
                res.result_value    = {57'd0, cnt};
                res.dest_write      = 1'b1;
                res.carry_flag      = src_zero;
                res.zero_flag       = (cnt == '0);
                res.flag_write_mask = MSK_CF | MSK_ZF;
            end
            ACT_BITADR:
            begin
                if (op.addr_is_64)
                begin
                    res.result_value = bit_addr;
                end
                else
                begin
                    res.result_value = {32'd0, bit_addr[31:0]};
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/bit_scan_test_count_unit64.sv
// ----------------------------------------------------------------------------
// bit_scan_test_count_unit64
// A 64-bit bit scan, bit test, population count and zero count unit that
// also steps bit-string addresses. Each item passes through an input
// register, one short combinational pass (one 64-bit subtract feeding a
// shared popcount tree, or the 64-bit address add) and a result register,
// so each result leaves from the result register. A new item is accepted
// every cycle unless the input side stalls. Both registers hold while the
// result side stalls, and the input side stalls only when both are full.
// ----------------------------------------------------------------------------
module bit_scan_test_count_unit64
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  bstc_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output bstc_pkg::rsp_t rsp
);
    import bstc_pkg::*;

    logic s1_valid_reg;
    logic s1_valid_next;
    req_t s1_item_reg;
    logic out_valid_reg;
    logic out_valid_next;
    rsp_t out_item_reg;
    rsp_t exec_rsp;
    logic s1_ready;
    logic out_ready;

    bstc_exec u_exec
    (
        .op  (s1_item_reg),
        .res (exec_rsp)
    );

    always_comb
    begin
        out_ready      = !out_valid_reg || !rsp_stall;
        s1_ready       = !s1_valid_reg || out_ready;
        s1_valid_next  = s1_ready ? req_valid : s1_valid_reg;
        out_valid_next = out_ready ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && req_valid)
        begin
            s1_item_reg <= req;
        end
        if (out_ready && s1_valid_reg)
        begin
            out_item_reg <= exec_rsp;
        end
    end

    assign req_stall = !s1_ready;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

endmodule

// File: verif/bstc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bstc_checker
// Watches both channels of the bit scan, test and count unit. It predicts the
// result of every accepted request item, keeps the predictions in order and
// compares each accepted result item with the oldest one, field by field.
// ----------------------------------------------------------------------------
module bstc_checker
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  bstc_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  bstc_pkg::rsp_t rsp,
    output int             mismatch_count,
    output int             pending_count
);
    import bstc_pkg::*;

    rsp_t predicted_q[$];

    // Works out the result of one operation from its request fields.
    function automatic rsp_t predict_bitop(input req_t r);
        rsp_t              o;
        logic [SEL_W-1:0]  sel;
        logic [WORD_W-1:0] one_hot;
        logic [WORD_W-1:0] qword_disp;
        logic [WORD_W-1:0] lowest_set;
        logic [WORD_W-1:0] lead_zeros;
        logic [WORD_W-1:0] ones;
        o          = '0;
        sel        = r.bit_offset[SEL_W-1:0];
        one_hot    = 64'd1 << sel;
        lowest_set = 64'd64;
        lead_zeros = 64'd64;
        ones       = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (r.source_value[i])
                lowest_set = 64'(i);
        end
        for (int i = 0; i < WORD_W; i++)
        begin
            if (r.source_value[i])
                lead_zeros = 64'(WORD_W - 1 - i);
            ones = ones + 64'(r.source_value[i]);
        end
        case (r.action)
            ACT_BSF, ACT_BSR:
            begin
                if (r.source_value == '0)
                begin
                    o.zero_flag       = 1'b1;
                    o.flag_write_mask = MSK_ZF;
                end
                else
                begin
                    o.result_value    = (r.action == ACT_BSF) ? lowest_set
                                                              : 64'd63 - lead_zeros;
                    o.dest_write      = 1'b1;
                    o.parity_flag     = ~^o.result_value[7:0];
                    o.sign_flag       = o.result_value[WORD_W-1];
                    o.flag_write_mask = MSK_ALL;
                end
            end
            ACT_BT, ACT_BTS, ACT_BTR, ACT_BTC:
            begin
                o.carry_flag      = r.source_value[sel];
                o.flag_write_mask = MSK_CF;
                o.dest_write      = (r.action != ACT_BT);
                case (r.action)
                    ACT_BTS: o.result_value = r.source_value | one_hot;
                    ACT_BTR: o.result_value = r.source_value & ~one_hot;
                    ACT_BTC: o.result_value = r.source_value ^ one_hot;
                    default: o.result_value = r.source_value;
                endcase
            end
            ACT_POPCNT:
            begin
                o.result_value    = ones;
                o.dest_write      = 1'b1;
                o.zero_flag       = (ones == '0);
                o.flag_write_mask = MSK_ALL;
            end
            ACT_TZCNT, ACT_LZCNT:
            begin
                o.result_value    = (r.action == ACT_TZCNT) ? lowest_set : lead_zeros;
                o.dest_write      = 1'b1;
                o.carry_flag      = (r.source_value == '0);
                o.zero_flag       = (o.result_value == '0);
                o.flag_write_mask = MSK_CF | MSK_ZF;
            end
            ACT_BITADR:
            begin
                // Upper offset bits are a signed qword displacement.
                qword_disp     = {{SEL_W{r.bit_offset[WORD_W-1]}},
                                  r.bit_offset[WORD_W-1:SEL_W]};
                o.result_value = r.base_address + (qword_disp << 3);
                if (!r.addr_is_64)
                    o.result_value[WORD_W-1:32] = '0;
            end
            default:
            begin
                o = '0;
            end
        endcase
        return o;
    endfunction

    always @(posedge clk)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            predicted_q.delete();
        end
        else
        begin
            if (req_valid && !req_stall)
                predicted_q.push_back(predict_bitop(req));
            if (rsp_valid && !rsp_stall)
            begin
                if (predicted_q.size() == 0)
                begin
                    $error("result item with no request pending: %h", rsp);
                    mismatch_count++;
                end
                else
                begin
                    want = predicted_q.pop_front();
                    if (rsp.result_value !== want.result_value)
                    begin
                        $error("result_value: expected %h, got %h",
                               want.result_value, rsp.result_value);
                        mismatch_count++;
                    end
                    if (rsp.dest_write !== want.dest_write)
                    begin
                        $error("dest_write: expected %b, got %b",
                               want.dest_write, rsp.dest_write);
                        mismatch_count++;
                    end
                    if (rsp.carry_flag !== want.carry_flag)
                    begin
                        $error("carry_flag: expected %b, got %b",
                               want.carry_flag, rsp.carry_flag);
                        mismatch_count++;
                    end
                    if (rsp.parity_flag !== want.parity_flag)
                    begin
                        $error("parity_flag: expected %b, got %b",
                               want.parity_flag, rsp.parity_flag);
                        mismatch_count++;
                    end
                    if (rsp.adjust_flag !== want.adjust_flag)
                    begin
                        $error("adjust_flag: expected %b, got %b",
                               want.adjust_flag, rsp.adjust_flag);
                        mismatch_count++;
                    end
                    if (rsp.zero_flag !== want.zero_flag)
                    begin
                        $error("zero_flag: expected %b, got %b",
                               want.zero_flag, rsp.zero_flag);
                        mismatch_count++;
                    end
                    if (rsp.sign_flag !== want.sign_flag)
                    begin
                        $error("sign_flag: expected %b, got %b",
                               want.sign_flag, rsp.sign_flag);
                        mismatch_count++;
                    end
                    if (rsp.overflow_flag !== want.overflow_flag)
                    begin
                        $error("overflow_flag: expected %b, got %b",
                               want.overflow_flag, rsp.overflow_flag);
                        mismatch_count++;
                    end
                    if (rsp.flag_write_mask !== want.flag_write_mask)
                    begin
                        $error("flag_write_mask: expected %h, got %h",
                               want.flag_write_mask, rsp.flag_write_mask);
                        mismatch_count++;
                    end
                end
            end
        end
        pending_count = predicted_q.size();
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the bit scan, test and count unit with directed corner items and
// then random items under several patterns of sender gaps and result stalls,
// including a long result hold-off. A checker beside the unit does the
// prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import bstc_pkg::*;

    localparam int ITEMS_PER_PHASE = 360;
    localparam int HOLD_ITEMS      = 30;
    localparam int HOLD_CYCLES     = 80;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    int mismatch_count;
    int pending_count;

    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_req  = 0;
    int unsigned hold_ack  = 0;
    int unsigned hold_left = 0;

    always #5 clk = ~clk;

    bit_scan_test_count_unit64 dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    bstc_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Result side: a requested hold-off wins over the random stalls.
    always @(negedge clk)
    begin
        if (hold_ack != hold_req)
        begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic req_t make_req(input logic [3:0] action, input logic [63:0] src,
                                      input logic [63:0] off, input logic [63:0] base,
                                      input logic a64);
        req_t r;
        r.action       = action;
        r.source_value = src;
        r.bit_offset   = off;
        r.base_address = base;
        r.addr_is_64   = a64;
        return r;
    endfunction

    // Operand shapes that move the lowest and highest set bits around.
    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(7))
            0: w = '0;
            1: w = '1;
            2: w = 64'd1 << $urandom_range(63);
            3: w = w & {$urandom, $urandom} & {$urandom, $urandom};
            4: w = w >> $urandom_range(63);
            5: w = w << $urandom_range(63);
            default: w = w;
        endcase
        return w;
    endfunction

    function automatic req_t rand_req();
        logic [3:0]  action;
        logic [63:0] off;
        if ($urandom_range(19) == 0)
            action = 4'($urandom_range(15, 10));
        else
            action = 4'($urandom_range(9));
        off = {$urandom, $urandom};
        if ($urandom_range(2) == 0)
            off = 64'($urandom_range(127));
        return make_req(action, rand_word(), off, {$urandom, $urandom}, 1'($urandom));
    endfunction

    // Entered and left at a falling edge; valid is lowered only during gaps.
    task automatic send_item(input req_t item);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
    endtask

    task automatic set_phase(input int unsigned idle, input int unsigned stall,
                             input bit hold);
        drain();
        @(posedge clk);
        idle_pct  = idle;
        stall_pct = stall;
        if (hold)
            hold_req++;
        @(negedge clk);
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
            send_item(rand_req());
    endtask

    initial
    begin
        #5000000;
        $display("bit_scan_test_count_unit64 test failed");
        $finish;
    end

    initial
    begin
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed corners: zero sources, top bits, wide offsets, unused codes.
        send_item(make_req(ACT_BSF, 64'd0, 64'd0, 64'd0, 1'b0));
        send_item(make_req(ACT_BSF, 64'h8000_0000_0000_0000, 64'd0, 64'd0, 1'b1));
        send_item(make_req(ACT_BSF, '1, '1, '1, 1'b1));
        send_item(make_req(ACT_BSR, 64'd0, '1, '1, 1'b1));
        send_item(make_req(ACT_BSR, 64'd1, 64'd0, 64'd0, 1'b0));
        send_item(make_req(ACT_BSR, '1, 64'd0, 64'd0, 1'b0));
        send_item(make_req(ACT_BT, '1, 64'd63, 64'd0, 1'b0));
        send_item(make_req(ACT_BT, 64'd0, 64'd0, 64'd0, 1'b1));
        send_item(make_req(ACT_BTS, 64'd0, '1, 64'd0, 1'b0));
        send_item(make_req(ACT_BTR, '1, 64'd64, 64'd0, 1'b0));
        send_item(make_req(ACT_BTC, 64'h5555_5555_5555_5555, 64'hffff_ffff_ffff_ffc5,
                           64'd0, 1'b1));
        send_item(make_req(ACT_POPCNT, 64'd0, 64'd0, 64'd0, 1'b0));
        send_item(make_req(ACT_POPCNT, '1, '1, '1, 1'b1));
        send_item(make_req(ACT_TZCNT, 64'd0, 64'd0, 64'd0, 1'b0));
        send_item(make_req(ACT_TZCNT, 64'd1, 64'd0, 64'd0, 1'b0));
        send_item(make_req(ACT_LZCNT, 64'd0, 64'd0, 64'd0, 1'b0));
        send_item(make_req(ACT_LZCNT, '1, 64'd0, 64'd0, 1'b0));
        send_item(make_req(ACT_BITADR, 64'd0, '1, 64'd0, 1'b1));
        send_item(make_req(ACT_BITADR, 64'd0, '1, 64'd0, 1'b0));
        send_item(make_req(ACT_BITADR, 64'd0, 64'h7fff_ffff_ffff_ffff, '1, 1'b1));
        send_item(make_req(ACT_BITADR, 64'd0, 64'h8000_0000_0000_0000, '1, 1'b0));
        send_item(make_req(4'd10, '1, '1, '1, 1'b1));
        send_item(make_req(4'd15, '1, '1, '1, 1'b1));

        run_random(ITEMS_PER_PHASE);
        set_phase(50, 0, 1'b0);
        run_random(ITEMS_PER_PHASE);
        set_phase(0, 50, 1'b0);
        run_random(ITEMS_PER_PHASE);
        set_phase(14, 14, 1'b0);
        run_random(ITEMS_PER_PHASE);

        // The result side holds off while items keep coming, so the unit
        // fills up and has to stall its input.
        set_phase(0, 0, 1'b1);
        run_random(HOLD_ITEMS);
        set_phase(14, 14, 1'b0);
        run_random(ITEMS_PER_PHASE / 4);

        drain();
        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("bit_scan_test_count_unit64 test passed");
        else
            $display("bit_scan_test_count_unit64 test failed");
        $finish;
    end

endmodule
